// ===== rtl/cdr_pkg.sv =====
// Package for the calendar date register: transaction types, operation codes,
// reset-date constants and small calendar lookup functions.
// Depends on nothing; used by calendar_date_register.
`default_nettype none

package cdr_pkg;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_INC  = 2'd1,
    OP_DEC  = 2'd2,
    OP_DIFF = 2'd3
  } cdr_op_t;

  typedef struct packed {
    cdr_op_t     operation;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [13:0] in_year;
  } cdr_item_t;

  typedef struct packed {
    logic [3:0]  cur_month_out;
    logic [4:0]  cur_day_out;
    logic [13:0] cur_year_out;
    logic        leap_year_flag;
    logic [4:0]  month_length;
    logic [21:0] day_difference;
    logic        set_rejected;
    logic        out_of_range;
  } cdr_result_t;

  // Limits of the supported calendar.
  localparam logic [13:0] YearMax = 14'd9999;
  localparam logic [13:0] YearMin = 14'd1;

  // The date loaded at reset and on a rejected set: 1 January 1900.
  localparam logic [3:0]  DefMonth = 4'd1;
  localparam logic [4:0]  DefDay   = 5'd1;
  localparam logic [13:0] DefYear  = 14'd1900;
  localparam logic [6:0]  DefCent  = 7'd19;
  localparam logic [6:0]  DefYoc   = 7'd0;
  // Day number of 1900-01-01, counting 0001-01-01 as day 1.
  localparam logic [21:0] DefDayNum = 22'd693596;

  // Reciprocal of 100 scaled by 2^19, exact for every 14-bit year.
  localparam logic [12:0] Recip100  = 13'd5243;
  localparam int          Recip100Sh = 19;

  // Days in all months before month m, common year.
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Days in month m; leap selects the February length.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_date_register.sv =====
// Calendar date register: holds a Gregorian date and applies one operation per
// transaction (set, step forward, step back, day difference).
// Depends on cdr_pkg for the transaction types, constants and calendar tables.
`default_nettype none

// Usage
// -----
// Input transactions arrive on item/item_valid and are taken at a rising edge
// where item_valid is high and item_stall is low. Each one produces exactly one
// result transaction on result/result_valid, taken when result_stall is low.
// The block has two register stages. The input register holds the accepted
// transaction together with its checked date and closed-form day number; the
// result register holds the stored date after the operation and the status.
// An accepted transaction passes through the input register and then the
// result register before its result can be taken. While the receiver does
// not stall, a new transaction can be accepted in every cycle, so sustained
// throughput is one per clock, set by the single pass from the input register,
// through the date stepping logic, into the state and result registers.
// When the receiver stalls, the result register holds its transaction, the
// input register fills behind it, and item_stall is raised only once both are
// occupied; nothing is lost or repeated. A synchronous reset on rst empties
// both stages and loads the stored date with 1 January 1900.
// The stored day number is kept alongside the date, so a difference is one
// subtraction; the year within its century is kept too, which gives the leap
// rule without any division on the stored date.

module calendar_date_register (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cdr_pkg::cdr_item_t item,
  input  wire logic               item_valid,
  output logic                    item_stall,
  output cdr_pkg::cdr_result_t    result,
  output logic                    result_valid,
  input  wire logic               result_stall
);

  // ---------------------------------------------------------------------------
  // Handshake. The input stage advances whenever the result register is empty
  // or is being emptied in this cycle.
  // ---------------------------------------------------------------------------
  logic in_full;
  logic advance;
  logic accept;

  assign advance    = in_full && (!result_valid || !result_stall);
  assign item_stall = in_full && !advance;
  assign accept     = item_valid && !item_stall;

  // ---------------------------------------------------------------------------
  // Input-side work on the arriving transaction: split the year into century
  // and year of century with a reciprocal multiply, check the date, and form
  // its day number. An invalid date is replaced by 1 January 1900.
  // ---------------------------------------------------------------------------
  logic [26:0] a_prod;
  logic [7:0]  a_cent;
  logic [13:0] a_cent100;
  logic [13:0] a_rem;
  logic [6:0]  a_yoc;
  logic        a_leap;
  logic [4:0]  a_mlen;
  logic        a_valid;
  logic [13:0] a_py;
  logic [7:0]  a_pcent;
  logic [21:0] a_dn;

  always_comb begin
    a_prod    = item.in_year * cdr_pkg::Recip100;
    a_cent    = a_prod[26:cdr_pkg::Recip100Sh];
    a_cent100 = {a_cent, 6'b0} + {1'b0, a_cent, 5'b0} + {4'b0, a_cent, 2'b0};
    a_rem     = item.in_year - a_cent100;
    a_yoc     = a_rem[6:0];
    a_leap    = (item.in_year[1:0] == 2'b00) && ((a_yoc != 7'd0) || (a_cent[1:0] == 2'b00));
    a_mlen    = cdr_pkg::month_len(item.in_month, a_leap);
    a_valid   = (item.in_month >= 4'd1) && (item.in_month <= 4'd12) &&
                (item.in_year >= cdr_pkg::YearMin) && (item.in_year <= cdr_pkg::YearMax) &&
                (item.in_day >= 5'd1) && (item.in_day <= a_mlen);
    // Whole years before this one, and whole centuries among them.
    a_py      = item.in_year - 14'd1;
    a_pcent   = (a_yoc == 7'd0) ? (a_cent - 8'd1) : a_cent;
    a_dn      = (22'(a_py) * 22'd365)
              + 22'(a_py[13:2])
              - 22'(a_pcent)
              + 22'(a_pcent[7:2])
              + 22'(cdr_pkg::days_before(item.in_month))
              + 22'(((item.in_month > 4'd2) && a_leap) ? 1'b1 : 1'b0)
              + 22'(item.in_day);
  end

  // Input register. Payload needs no reset.
  cdr_pkg::cdr_op_t op_q;
  logic [3:0]       mon_q;
  logic [4:0]       day_q;
  logic [13:0]      year_q;
  logic [6:0]       cent_q;
  logic [6:0]       yoc_q;
  logic [21:0]      dn_q;
  logic             bad_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= item.operation;
      bad_q <= !a_valid;
      if (a_valid) begin
        mon_q  <= item.in_month;
        day_q  <= item.in_day;
        year_q <= item.in_year;
        cent_q <= a_cent[6:0];
        yoc_q  <= a_yoc;
        dn_q   <= a_dn;
      end else begin
        mon_q  <= cdr_pkg::DefMonth;
        day_q  <= cdr_pkg::DefDay;
        year_q <= cdr_pkg::DefYear;
        cent_q <= cdr_pkg::DefCent;
        yoc_q  <= cdr_pkg::DefYoc;
        dn_q   <= cdr_pkg::DefDayNum;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stored date. Century and year of century always agree with the year, and
  // the day number always matches the date.
  // ---------------------------------------------------------------------------
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic [13:0] cur_year;
  logic [6:0]  cur_cent;
  logic [6:0]  cur_yoc;
  logic [21:0] cur_dn;

  logic [3:0]  cur_month_next;
  logic [4:0]  cur_day_next;
  logic [13:0] cur_year_next;
  logic [6:0]  cur_cent_next;
  logic [6:0]  cur_yoc_next;
  logic [21:0] cur_dn_next;

  logic        cur_leap;
  logic [4:0]  cur_mlen;
  logic        next_leap;
  logic        oor;
  logic [21:0] diff;

  assign cur_leap = (cur_year[1:0] == 2'b00) && ((cur_yoc != 7'd0) || (cur_cent[1:0] == 2'b00));
  assign cur_mlen = cdr_pkg::month_len(cur_month, cur_leap);

  always_comb begin
    cur_month_next = cur_month;
    cur_day_next   = cur_day;
    cur_year_next  = cur_year;
    cur_cent_next  = cur_cent;
    cur_yoc_next   = cur_yoc;
    cur_dn_next    = cur_dn;
    oor            = 1'b0;
    diff           = 22'd0;
    next_leap      = cur_leap;

    case (op_q)
      cdr_pkg::OP_SET: begin
        cur_month_next = mon_q;
        cur_day_next   = day_q;
        cur_year_next  = year_q;
        cur_cent_next  = cent_q;
        cur_yoc_next   = yoc_q;
        cur_dn_next    = dn_q;
      end
      cdr_pkg::OP_INC: begin
        if ((cur_year == cdr_pkg::YearMax) && (cur_month == 4'd12) && (cur_day == 5'd31)) begin
          oor = 1'b1;
        end else begin
          cur_dn_next = cur_dn + 22'd1;
          if (cur_day < cur_mlen) begin
            cur_day_next = cur_day + 5'd1;
          end else begin
            cur_day_next = 5'd1;
            if (cur_month < 4'd12) begin
              cur_month_next = cur_month + 4'd1;
            end else begin
              cur_month_next = 4'd1;
              cur_year_next  = cur_year + 14'd1;
              if (cur_yoc == 7'd99) begin
                cur_yoc_next  = 7'd0;
                cur_cent_next = cur_cent + 7'd1;
              end else begin
                cur_yoc_next = cur_yoc + 7'd1;
              end
            end
          end
        end
      end
      cdr_pkg::OP_DEC: begin
        if ((cur_year == cdr_pkg::YearMin) && (cur_month == 4'd1) && (cur_day == 5'd1)) begin
          oor = 1'b1;
        end else begin
          cur_dn_next = cur_dn - 22'd1;
          if (cur_day > 5'd1) begin
            cur_day_next = cur_day - 5'd1;
          end else begin
            if (cur_month > 4'd1) begin
              cur_month_next = cur_month - 4'd1;
            end else begin
              cur_month_next = 4'd12;
              cur_year_next  = cur_year - 14'd1;
              if (cur_yoc == 7'd0) begin
                cur_yoc_next  = 7'd99;
                cur_cent_next = cur_cent - 7'd1;
              end else begin
                cur_yoc_next = cur_yoc - 7'd1;
              end
            end
            next_leap = (cur_year_next[1:0] == 2'b00) &&
                        ((cur_yoc_next != 7'd0) || (cur_cent_next[1:0] == 2'b00));
            cur_day_next = cdr_pkg::month_len(cur_month_next, next_leap);
          end
        end
      end
      cdr_pkg::OP_DIFF: begin
        diff = (cur_dn >= dn_q) ? (cur_dn - dn_q) : (dn_q - cur_dn);
      end
      default: begin
        diff = 22'd0;
      end
    endcase

    next_leap = (cur_year_next[1:0] == 2'b00) &&
                ((cur_yoc_next != 7'd0) || (cur_cent_next[1:0] == 2'b00));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_month <= cdr_pkg::DefMonth;
      cur_day   <= cdr_pkg::DefDay;
      cur_year  <= cdr_pkg::DefYear;
      cur_cent  <= cdr_pkg::DefCent;
      cur_yoc   <= cdr_pkg::DefYoc;
      cur_dn    <= cdr_pkg::DefDayNum;
    end else if (advance) begin
      cur_month <= cur_month_next;
      cur_day   <= cur_day_next;
      cur_year  <= cur_year_next;
      cur_cent  <= cur_cent_next;
      cur_yoc   <= cur_yoc_next;
      cur_dn    <= cur_dn_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.cur_month_out  <= cur_month_next;
      result.cur_day_out    <= cur_day_next;
      result.cur_year_out   <= cur_year_next;
      result.leap_year_flag <= next_leap;
      result.month_length   <= cdr_pkg::month_len(cur_month_next, next_leap);
      result.day_difference <= diff;
      result.set_rejected   <= (op_q == cdr_pkg::OP_SET) && bad_q;
      result.out_of_range   <= oor;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The stored date is always a real calendar date.
  assert property (@(posedge clk) disable iff (rst)
    (cur_month >= 4'd1) && (cur_month <= 4'd12) && (cur_day >= 5'd1) && (cur_day <= cur_mlen))
    else $error("stored date is not a valid calendar date");

  // Century and year of century stay consistent with the year.
  assert property (@(posedge clk) disable iff (rst)
    ((14'(cur_cent) * 14'd100) + 14'(cur_yoc) == cur_year) && (cur_yoc < 7'd100))
    else $error("century split of the stored year is inconsistent");

  // A refused step leaves the day number and the stored year untouched.
  assert property (@(posedge clk) disable iff (rst)
    advance && oor |=> (cur_dn == $past(cur_dn)) && (cur_year == $past(cur_year)))
    else $error("refused step changed the stored date");

  // A forward step that is carried out moves the day number up by exactly one.
  assert property (@(posedge clk) disable iff (rst)
    advance && !oor && (op_q == cdr_pkg::OP_INC) |=> (cur_dn == $past(cur_dn) + 22'd1))
    else $error("forward step did not advance the day number by one");

endmodule

`default_nettype wire

// ===== tb/tb_calendar_date_register.sv =====
// Self-checking testbench for calendar_date_register: directed rows, then random
// transactions, all checked against a date predictor kept inside this module.
// Depends on cdr_pkg and calendar_date_register only.
`timescale 1ns / 100ps

module tb_calendar_date_register;

  // Generous bound on the run.
  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 1550;
  localparam int ReportLimit = 10;

  // One row of the directed stimulus. Where typed is set, want holds the result
  // written out by hand; otherwise the predictor supplies it.
  typedef struct packed {
    cdr_pkg::cdr_item_t   stim;
    logic                 typed;
    cdr_pkg::cdr_result_t want;
  } dated_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  cdr_pkg::cdr_item_t   item = '0;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  cdr_pkg::cdr_result_t result;
  logic                 result_valid;
  logic                 result_stall = 1'b0;

  // The predictor's own copy of the stored date, starting from the reset date.
  int held_month = int'(cdr_pkg::DefMonth);
  int held_day   = int'(cdr_pkg::DefDay);
  int held_year  = int'(cdr_pkg::DefYear);

  cdr_pkg::cdr_result_t awaited_results[$];
  dated_row_t           directed_rows[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int items_sent     = 0;
  int burst_left     = 0;
  int stall_style    = 0;
  int stall_left     = 0;
  int stall_tick     = 0;

  calendar_date_register u_dut (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the predictor.
  // ---------------------------------------------------------------------------

  // Gregorian rule: every fourth year, but not a century unless divisible by 400.
  function automatic logic is_leap(input int y);
    if (y % 100 == 0 && y % 400 != 0) begin
      return 1'b0;
    end
    return (y % 4 == 0);
  endfunction

  function automatic int days_in_month(input int m, input int y);
    case (m)
      2:           return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic logic is_real_date(input int m, input int d, input int y);
    if (m < 1 || m > 12 || y < int'(cdr_pkg::YearMin) || y > int'(cdr_pkg::YearMax)) begin
      return 1'b0;
    end
    return (d >= 1 && d <= days_in_month(m, y));
  endfunction

  // Ordinal of a valid date, with 1 January of year 1 as day 1. Earlier months
  // of the same year are summed directly rather than looked up.
  function automatic int day_ordinal(input int m, input int d, input int y);
    int past;
    int n;
    past = y - 1;
    n = past * 365 + past / 4 - past / 100 + past / 400;
    for (int k = 1; k < m; k++) begin
      n += days_in_month(k, y);
    end
    return n + d;
  endfunction

  // Applies one transaction to the held date and returns the result it should
  // produce. Every transaction yields exactly one result.
  task automatic advance_date(input cdr_pkg::cdr_item_t it, output cdr_pkg::cdr_result_t r);
    int m;
    int d;
    int y;
    int ours;
    int theirs;
    m = int'(it.in_month);
    d = int'(it.in_day);
    y = int'(it.in_year);
    r = '0;
    case (it.operation)
      cdr_pkg::OP_SET: begin
        if (is_real_date(m, d, y)) begin
          held_month = m;
          held_day   = d;
          held_year  = y;
        end else begin
          held_month = int'(cdr_pkg::DefMonth);
          held_day   = int'(cdr_pkg::DefDay);
          held_year  = int'(cdr_pkg::DefYear);
          r.set_rejected = 1'b1;
        end
      end
      cdr_pkg::OP_INC: begin
        if (held_year == int'(cdr_pkg::YearMax) && held_month == 12 && held_day == 31) begin
          r.out_of_range = 1'b1;
        end else if (held_day < days_in_month(held_month, held_year)) begin
          held_day++;
        end else begin
          held_day = 1;
          if (held_month < 12) begin
            held_month++;
          end else begin
            held_month = 1;
            held_year++;
          end
        end
      end
      cdr_pkg::OP_DEC: begin
        if (held_year == int'(cdr_pkg::YearMin) && held_month == 1 && held_day == 1) begin
          r.out_of_range = 1'b1;
        end else if (held_day > 1) begin
          held_day--;
        end else begin
          if (held_month > 1) begin
            held_month--;
          end else begin
            held_month = 12;
            held_year--;
          end
          held_day = days_in_month(held_month, held_year);
        end
      end
      default: begin
        // An invalid operand is measured as if it were the default date.
        if (!is_real_date(m, d, y)) begin
          m = int'(cdr_pkg::DefMonth);
          d = int'(cdr_pkg::DefDay);
          y = int'(cdr_pkg::DefYear);
        end
        ours   = day_ordinal(held_month, held_day, held_year);
        theirs = day_ordinal(m, d, y);
        r.day_difference = 22'((ours >= theirs) ? ours - theirs : theirs - ours);
      end
    endcase
    r.cur_month_out  = 4'(held_month);
    r.cur_day_out    = 5'(held_day);
    r.cur_year_out   = 14'(held_year);
    r.leap_year_flag = is_leap(held_year);
    r.month_length   = 5'(days_in_month(held_month, held_year));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic cdr_pkg::cdr_item_t make_item(input cdr_pkg::cdr_op_t op, input int m,
                                                   input int d, input int y);
    cdr_pkg::cdr_item_t it;
    it.operation = op;
    it.in_month  = m[3:0];
    it.in_day    = d[4:0];
    it.in_year   = y[13:0];
    return it;
  endfunction

  function automatic cdr_pkg::cdr_result_t mk_result(input int m, input int d, input int y,
                                                     input logic lp, input int len,
                                                     input int diff, input logic rej,
                                                     input logic oor);
    cdr_pkg::cdr_result_t r;
    r.cur_month_out  = m[3:0];
    r.cur_day_out    = d[4:0];
    r.cur_year_out   = y[13:0];
    r.leap_year_flag = lp;
    r.month_length   = len[4:0];
    r.day_difference = diff[21:0];
    r.set_rejected   = rej;
    r.out_of_range   = oor;
    return r;
  endfunction

  task automatic add_row(input cdr_pkg::cdr_op_t op, input int m, input int d, input int y,
                         input logic typed, input cdr_pkg::cdr_result_t want);
    dated_row_t row;
    row.stim  = make_item(op, m, d, y);
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Years are drawn with weight on the calendar's ends, on century years and on
  // the years around the default date, where the leap rule and limits bite.
  function automatic int pick_year();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, 4);
      1:       return $urandom_range(9996, 9999);
      2:       return 100 * $urandom_range(1, 99);
      3:       return 400 * $urandom_range(1, 24);
      4:       return $urandom_range(1899, 2101);
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  function automatic cdr_pkg::cdr_item_t valid_item(input cdr_pkg::cdr_op_t op);
    int y;
    int m;
    y = pick_year();
    m = $urandom_range(1, 12);
    return make_item(op, m, $urandom_range(1, days_in_month(m, y)), y);
  endfunction

  // Presents one transaction, called at a falling edge and returning at one.
  // The sender works in bursts; when a burst runs out it may idle before the
  // next. Some bursts are long and follow no gap at all. The expectation is
  // queued at the rising edge where the transaction is taken.
  task automatic offer_item(input cdr_pkg::cdr_item_t it, input logic typed,
                            input cdr_pkg::cdr_result_t want);
    cdr_pkg::cdr_result_t predicted;
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
        burst_left = $urandom_range(20, 80);
      end else begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end
      repeat (gap) begin
        item_valid <= 1'b0;
        @(negedge clk);
      end
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) begin
      @(posedge clk);
    end
    advance_date(it, predicted);
    awaited_results.push_back(typed ? want : predicted);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  // Holds the sender off until every outstanding result has been taken.
  task automatic wait_for_quiet();
    item_valid <= 1'b0;
    while (awaited_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stalls in phases, each with its own
  // character (never, lightly at random, heavily at random, or in a regular
  // repeating pattern), so that stalls land on every stage of the pipeline.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(64, 300);
    end
    stall_left--;
    stall_tick++;
    case (stall_style)
      0:       result_stall <= 1'b0;
      1:       result_stall <= ($urandom_range(0, 3) == 0);
      2:       result_stall <= ($urandom_range(0, 9) < 6);
      default: result_stall <= ((stall_tick % 5) < 2);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checking: each result taken is matched field by field against the
  // oldest expectation. Only the first few failures are described in full.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    cdr_pkg::cdr_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("Unexpected result transaction at cycle %0d", cycle_count);
        end
      end else begin
        want = awaited_results.pop_front();
        if (result.cur_month_out  !== want.cur_month_out  ||
            result.cur_day_out    !== want.cur_day_out    ||
            result.cur_year_out   !== want.cur_year_out   ||
            result.leap_year_flag !== want.leap_year_flag ||
            result.month_length   !== want.month_length   ||
            result.day_difference !== want.day_difference ||
            result.set_rejected   !== want.set_rejected   ||
            result.out_of_range   !== want.out_of_range) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("Mismatch at cycle %0d: expected %0d-%0d-%0d leap %0b len %0d",
                     cycle_count, want.cur_year_out, want.cur_month_out,
                     want.cur_day_out, want.leap_year_flag, want.month_length);
            $display("  expected diff %0d rej %0b oor %0b; got %0d-%0d-%0d leap %0b",
                     want.day_difference, want.set_rejected, want.out_of_range,
                     result.cur_year_out, result.cur_month_out, result.cur_day_out,
                     result.leap_year_flag);
            $display("  got len %0d diff %0d rej %0b oor %0b", result.month_length,
                     result.day_difference, result.set_rejected, result.out_of_range);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int pick;
    int steps;
    int y;
    int m;
    int len;
    int d;
    logic [24:0] raw;
    cdr_pkg::cdr_op_t heading;
    cdr_pkg::cdr_op_t op;

    // Directed rows. Results that can be read straight off the calendar are
    // written out; the rest are left to the predictor.
    add_row(cdr_pkg::OP_DIFF, 1, 1, 1900, 1'b1,
            mk_result(1, 1, 1900, 1'b0, 31, 0, 1'b0, 1'b0));
    add_row(cdr_pkg::OP_SET, 12, 31, 9999, 1'b1,
            mk_result(12, 31, 9999, 1'b0, 31, 0, 1'b0, 1'b0));
    // Stepping past the last supported day is refused.
    add_row(cdr_pkg::OP_INC, 0, 0, 0, 1'b1,
            mk_result(12, 31, 9999, 1'b0, 31, 0, 1'b0, 1'b1));
    // The widest possible span, first day to last.
    add_row(cdr_pkg::OP_DIFF, 1, 1, 1, 1'b1,
            mk_result(12, 31, 9999, 1'b0, 31, 3652058, 1'b0, 1'b0));
    add_row(cdr_pkg::OP_SET, 1, 1, 1, 1'b1, mk_result(1, 1, 1, 1'b0, 31, 0, 1'b0, 1'b0));
    // Stepping back from the first supported day is refused.
    add_row(cdr_pkg::OP_DEC, 15, 31, 16383, 1'b1,
            mk_result(1, 1, 1, 1'b0, 31, 0, 1'b0, 1'b1));
    add_row(cdr_pkg::OP_INC, 0, 0, 0, 1'b0, '0);
    // Invalid sets: month zero, month beyond twelve, day zero, year zero, year
    // beyond the range, the 29th of February in a common century year, and a
    // day past the end of a thirty-day month. Each loads the default date.
    add_row(cdr_pkg::OP_SET, 0, 5, 2000, 1'b1,
            mk_result(1, 1, 1900, 1'b0, 31, 0, 1'b1, 1'b0));
    add_row(cdr_pkg::OP_SET, 15, 31, 16383, 1'b1,
            mk_result(1, 1, 1900, 1'b0, 31, 0, 1'b1, 1'b0));
    add_row(cdr_pkg::OP_SET, 6, 0, 2020, 1'b1,
            mk_result(1, 1, 1900, 1'b0, 31, 0, 1'b1, 1'b0));
    add_row(cdr_pkg::OP_SET, 3, 10, 0, 1'b1,
            mk_result(1, 1, 1900, 1'b0, 31, 0, 1'b1, 1'b0));
    add_row(cdr_pkg::OP_SET, 3, 10, 10000, 1'b1,
            mk_result(1, 1, 1900, 1'b0, 31, 0, 1'b1, 1'b0));
    add_row(cdr_pkg::OP_SET, 2, 29, 1900, 1'b1,
            mk_result(1, 1, 1900, 1'b0, 31, 0, 1'b1, 1'b0));
    add_row(cdr_pkg::OP_SET, 4, 31, 2023, 1'b1,
            mk_result(1, 1, 1900, 1'b0, 31, 0, 1'b1, 1'b0));
    // Leap day in a year divisible by 400, and the month boundary around it.
    add_row(cdr_pkg::OP_SET, 2, 29, 2000, 1'b1,
            mk_result(2, 29, 2000, 1'b1, 29, 0, 1'b0, 1'b0));
    add_row(cdr_pkg::OP_INC, 0, 0, 0, 1'b0, '0);
    add_row(cdr_pkg::OP_DEC, 0, 0, 0, 1'b0, '0);
    // A common century year ends February on the 28th.
    add_row(cdr_pkg::OP_SET, 2, 28, 2100, 1'b1,
            mk_result(2, 28, 2100, 1'b0, 28, 0, 1'b0, 1'b0));
    add_row(cdr_pkg::OP_INC, 0, 0, 0, 1'b0, '0);
    // Year rollover in both directions.
    add_row(cdr_pkg::OP_SET, 12, 31, 2023, 1'b1,
            mk_result(12, 31, 2023, 1'b0, 31, 0, 1'b0, 1'b0));
    add_row(cdr_pkg::OP_INC, 0, 0, 0, 1'b0, '0);
    add_row(cdr_pkg::OP_DEC, 0, 0, 0, 1'b0, '0);
    // An invalid difference operand is measured as the default date, without
    // touching the stored date or raising the rejected flag.
    add_row(cdr_pkg::OP_DIFF, 0, 0, 0, 1'b0, '0);
    add_row(cdr_pkg::OP_DIFF, 13, 31, 16383, 1'b0, '0);
    add_row(cdr_pkg::OP_DIFF, 12, 31, 2023, 1'b0, '0);

    // Reset is released on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end
    wait_for_quiet();

    // Random part. Most transactions form short scenarios: a valid set close to
    // a month boundary followed by a run of steps, or a set at either end of the
    // calendar followed by steps towards that end. Differences and plain sets
    // use valid dates; the rest is raw noise across every field.
    items_sent = 0;
    while (items_sent < RandomItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        y = pick_year();
        m = $urandom_range(1, 12);
        len = days_in_month(m, y);
        d = $urandom_range(0, 1) ? len - $urandom_range(0, 2) : 1 + $urandom_range(0, 2);
        offer_item(make_item(cdr_pkg::OP_SET, m, d, y), 1'b0, '0);
        heading = $urandom_range(0, 1) ? cdr_pkg::OP_INC : cdr_pkg::OP_DEC;
        steps = $urandom_range(1, 40);
        repeat (steps) begin
          case ($urandom_range(0, 9))
            0:       op = (heading == cdr_pkg::OP_INC) ? cdr_pkg::OP_DEC : cdr_pkg::OP_INC;
            1:       op = cdr_pkg::OP_DIFF;
            default: op = heading;
          endcase
          offer_item(op == cdr_pkg::OP_DIFF ? valid_item(cdr_pkg::OP_DIFF)
                                            : make_item(op, 0, 0, 0), 1'b0, '0);
        end
      end else if (pick < 45) begin
        if ($urandom_range(0, 1)) begin
          offer_item(make_item(cdr_pkg::OP_SET, 12, $urandom_range(28, 31), 9999), 1'b0, '0);
          heading = cdr_pkg::OP_INC;
        end else begin
          offer_item(make_item(cdr_pkg::OP_SET, 1, $urandom_range(1, 4), 1), 1'b0, '0);
          heading = cdr_pkg::OP_DEC;
        end
        steps = $urandom_range(1, 6);
        repeat (steps) begin
          offer_item(make_item(heading, 0, 0, 0), 1'b0, '0);
        end
      end else if (pick < 65) begin
        offer_item(valid_item(cdr_pkg::OP_DIFF), 1'b0, '0);
      end else if (pick < 80) begin
        offer_item(valid_item(cdr_pkg::OP_SET), 1'b0, '0);
      end else begin
        raw = 25'($urandom);
        offer_item(cdr_pkg::cdr_item_t'(raw), 1'b0, '0);
      end
      // Now and then the sender holds off until the pipeline has fully drained.
      if ($urandom_range(0, 59) == 0) begin
        wait_for_quiet();
      end
    end

    wait_for_quiet();
    // Waiting on afterwards catches any stray result arriving after the last one.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
